// ----- hdl/rotation_matrix_to_quaternion_assert.svh -----
// Assertion macros shared by the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RMQ_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rmq assertion failed");
`define RMQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rmq assertion failed");
`else
`define RMQ_ASSERT_SAME(label, clk, rst_n, a, b)
`define RMQ_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- hdl/rmq_pkg.sv -----
// Shared types and constants of the rotation matrix to quaternion block.
`default_nettype none
package rmq_pkg;
    typedef logic [1:0] t_slot;
    localparam t_slot SLOT_X = 2'd0;
    localparam t_slot SLOT_Y = 2'd1;
    localparam t_slot SLOT_Z = 2'd2;
    localparam t_slot SLOT_W = 2'd3;
    localparam int QBITS = 17;
    localparam int Q_MAX = 32767;
    localparam int Q_MIN_MAG = 32768;
endpackage
`default_nettype wire

// ----- hdl/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rmq_sqrt #(
    parameter int SW = 33,
    parameter int PW = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [SW-1:0]             i_rad,
    input  wire logic [PW-1:0]             i_pl,
    output logic                           o_valid,
    output logic [(SW+1)/2-1:0]            o_root,
    output logic [PW-1:0]                  o_pl
);
    localparam int RTW = (SW + 1) / 2;
    localparam int TW = 2 * RTW + 1;

    logic [SW-1:0]  rem_a  [RTW+1];
    logic [RTW-1:0] root_a [RTW+1];
    logic [PW-1:0]  pl_a   [RTW+1];
    logic           v_a    [RTW+1];

    assign rem_a[0]  = i_rad;
    assign root_a[0] = '0;
    assign pl_a[0]   = i_pl;
    assign v_a[0]    = i_valid;

    for (genvar s = 0; s < RTW; s++) begin : g_st
        localparam int B = RTW - 1 - s;
        logic [TW-1:0]  t;
        logic [TW-1:0]  rem_x;
        logic           ge;
        logic [SW-1:0]  r_rem;
        logic [RTW-1:0] r_root;
        logic [PW-1:0]  r_pl;
        logic           r_v;

        assign rem_x = TW'(rem_a[s]);
        assign t     = (TW'(root_a[s]) << (B + 1)) | (TW'(1) << (2 * B));
        assign ge    = rem_x >= t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= v_a[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? SW'(rem_x - t) : rem_a[s];
                r_root <= ge ? (root_a[s] | (RTW'(1) << B)) : root_a[s];
                r_pl   <= pl_a[s];
            end
        end

        assign rem_a[s+1]  = r_rem;
        assign root_a[s+1] = r_root;
        assign pl_a[s+1]   = r_pl;
        assign v_a[s+1]    = r_v;
    end

    assign o_valid = v_a[RTW];
    assign o_root  = root_a[RTW];
    assign o_pl    = pl_a[RTW];
endmodule
`default_nettype wire

// ----- hdl/rmq_div.sv -----
// Pipelined three-lane restoring divider with shared divisor and per-lane overflow flags.
`default_nettype none
module rmq_div #(
    parameter int NW = 32,
    parameter int DW = 18,
    parameter int PW = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [2:0][NW-1:0]                i_num,
    input  wire logic [DW-1:0]                     i_den,
    input  wire logic [PW-1:0]                     i_pl,
    output logic                                   o_valid,
    output logic [2:0][rmq_pkg::QBITS-1:0]         o_quo,
    output logic [2:0]                             o_ovf,
    output logic [PW-1:0]                          o_pl
);
    localparam int QB = rmq_pkg::QBITS;
    localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic [2:0][NW-1:0] rem_a [QB+1];
    logic [2:0][QB-1:0] quo_a [QB+1];
    logic [2:0]         ovf_a [QB+1];
    logic [DW-1:0]      den_a [QB+1];
    logic [PW-1:0]      pl_a  [QB+1];
    logic               v_a   [QB+1];

    assign rem_a[0] = i_num;
    assign quo_a[0] = '0;
    assign ovf_a[0] = '0;
    assign den_a[0] = i_den;
    assign pl_a[0]  = i_pl;
    assign v_a[0]   = i_valid;

    for (genvar s = 0; s < QB; s++) begin : g_st
        localparam int B = QB - 1 - s;
        logic [CW-1:0]      t;
        logic [2:0][NW-1:0] n_rem;
        logic [2:0][QB-1:0] n_quo;
        logic [2:0]         n_ovf;
        logic [2:0][NW-1:0] r_rem;
        logic [2:0][QB-1:0] r_quo;
        logic [2:0]         r_ovf;
        logic [DW-1:0]      r_den;
        logic [PW-1:0]      r_pl;
        logic               r_v;

        assign t = CW'(den_a[s]) << B;

        for (genvar l = 0; l < 3; l++) begin : g_ln
            logic ge;
            assign ge       = CW'(rem_a[s][l]) >= t;
            assign n_rem[l] = ge ? NW'(CW'(rem_a[s][l]) - t) : rem_a[s][l];
            assign n_quo[l] = ge ? (quo_a[s][l] | (QB'(1) << B)) : quo_a[s][l];
            if (s == 0) begin : g_ovf
                assign n_ovf[l] = CW'(rem_a[s][l]) >= (CW'(den_a[s]) << QB);
            end else begin : g_pass
                assign n_ovf[l] = ovf_a[s][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= v_a[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_ovf <= n_ovf;
                r_den <= den_a[s];
                r_pl  <= pl_a[s];
            end
        end

        assign rem_a[s+1] = r_rem;
        assign quo_a[s+1] = r_quo;
        assign ovf_a[s+1] = r_ovf;
        assign den_a[s+1] = r_den;
        assign pl_a[s+1]  = r_pl;
        assign v_a[s+1]   = r_v;
    end

    assign o_valid = v_a[QB];
    assign o_quo   = quo_a[QB];
    assign o_ovf   = ovf_a[QB];
    assign o_pl    = pl_a[QB];
endmodule
`default_nettype wire

// ----- hdl/rotation_matrix_to_quaternion.sv -----
// Top level: rotation matrix (Q2.14) to unit quaternion, fully pipelined.
// Takes one matrix per cycle unless the sink holds the output, and returns one quaternion per matrix, in order.
// The pipeline is one setup stage, one square-root stage per root bit, one
// divider stage per quotient bit and one output stage. When the output is
// held by the sink, the whole pipeline holds and the input is not ready.
`default_nettype none
`include "rotation_matrix_to_quaternion_assert.svh"
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, low first)
    input  wire logic [143:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // qx, qy, qz, qw (16 bits each, low first)
    output logic [63:0]       o_m_axis_tdata,
    // degenerate
    output logic              o_m_axis_tuser
);
    localparam int F    = FRAC_BITS;
    localparam int RADW = ((F > 17) ? F : 17) + 2;
    localparam int XW   = RADW + 1;
    localparam int SW   = RADW + F;
    localparam int RTW  = (SW + 1) / 2;
    localparam int NW   = 18 + F;
    localparam int DW   = RTW + 1;
    localparam int QB   = rmq_pkg::QBITS;
    localparam int P1W  = 2 + 1 + 3 * 17 + 3;
    localparam int P2W  = 2 + 1 + 3 + 16;
    localparam logic signed [XW-1:0] ONE = XW'(1) << F;

    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // setup stage
    logic signed [15:0] m [9];
    logic signed [XW-1:0] e00, e11, e22, tr, rad;
    logic signed [16:0] n_num [3];
    logic               i1, i2;
    logic signed [15:0] mi;
    rmq_pkg::t_slot     n_slot;
    logic               n_degen;

    for (genvar g = 0; g < 9; g++) begin : g_m
        assign m[g] = i_s_axis_tdata[16*g +: 16];
    end

    assign e00 = XW'(m[0]);
    assign e11 = XW'(m[4]);
    assign e22 = XW'(m[8]);
    assign tr  = e00 + e11 + e22;
    assign i1  = m[4] > m[0];
    assign mi  = i1 ? m[4] : m[0];
    assign i2  = m[8] > mi;

    always_comb begin
        if (tr > 0) begin
            n_slot = rmq_pkg::SLOT_W;
        end else if (i2) begin
            n_slot = rmq_pkg::SLOT_Z;
        end else if (i1) begin
            n_slot = rmq_pkg::SLOT_Y;
        end else begin
            n_slot = rmq_pkg::SLOT_X;
        end
    end

    always_comb begin
        unique case (n_slot)
            rmq_pkg::SLOT_X: begin
                rad      = e00 - e11 - e22 + ONE;
                n_num[0] = 17'(m[1]) + 17'(m[3]);
                n_num[1] = 17'(m[2]) + 17'(m[6]);
                n_num[2] = 17'(m[5]) - 17'(m[7]);
            end
            rmq_pkg::SLOT_Y: begin
                rad      = e11 - e22 - e00 + ONE;
                n_num[0] = 17'(m[3]) + 17'(m[1]);
                n_num[1] = 17'(m[5]) + 17'(m[7]);
                n_num[2] = 17'(m[6]) - 17'(m[2]);
            end
            rmq_pkg::SLOT_Z: begin
                rad      = e22 - e00 - e11 + ONE;
                n_num[0] = 17'(m[6]) + 17'(m[2]);
                n_num[1] = 17'(m[7]) + 17'(m[5]);
                n_num[2] = 17'(m[1]) - 17'(m[3]);
            end
            default: begin
                rad      = tr + ONE;
                n_num[0] = 17'(m[5]) - 17'(m[7]);
                n_num[1] = 17'(m[6]) - 17'(m[2]);
                n_num[2] = 17'(m[1]) - 17'(m[3]);
            end
        endcase
    end

    assign n_degen = rad <= 0;

    logic              r1_v;
    logic [SW-1:0]     r1_rad;
    logic [2:0][16:0]  r1_mag;
    logic [2:0]        r1_neg;
    rmq_pkg::t_slot    r1_slot;
    logic              r1_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_rad   <= n_degen ? '0 : {rad[RADW-1:0], {F{1'b0}}};
            r1_slot  <= n_slot;
            r1_degen <= n_degen;
            for (int l = 0; l < 3; l++) begin
                r1_neg[l] <= n_num[l][16];
                r1_mag[l] <= n_num[l][16] ? 17'(-n_num[l]) : 17'(n_num[l]);
            end
        end
    end

    // square root
    logic           s_v;
    logic [RTW-1:0] s_root;
    logic [P1W-1:0] s_pl;

    rmq_sqrt #(.SW(SW), .PW(P1W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_rad   (r1_rad),
        .i_pl    ({r1_slot, r1_degen, r1_mag, r1_neg}),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_pl    (s_pl)
    );

    rmq_pkg::t_slot     s_slot;
    logic               s_degen;
    logic [2:0][16:0]   s_mag;
    logic [2:0]         s_neg;
    logic [2:0][NW-1:0] s_num;
    logic [RTW:0]       s_rp;
    logic [RTW-1:0]     s_half;
    logic [15:0]        s_rootc;

    assign {s_slot, s_degen, s_mag, s_neg} = s_pl;
    assign s_rp   = (RTW + 1)'(s_root) + (RTW + 1)'(1);
    assign s_half = s_rp[RTW:1];
    assign s_rootc = (32'(s_half) > 32'(rmq_pkg::Q_MAX)) ? 16'(rmq_pkg::Q_MAX)
                                                         : 16'(s_half);

    for (genvar l = 0; l < 3; l++) begin : g_num
        assign s_num[l] = (NW'(s_mag[l]) << F) + NW'(s_root);
    end

    // divide
    logic              d_v;
    logic [2:0][QB-1:0] d_quo;
    logic [2:0]        d_ovf;
    logic [P2W-1:0]    d_pl;

    rmq_div #(.NW(NW), .DW(DW), .PW(P2W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_v),
        .i_num   (s_num),
        .i_den   ({s_root, 1'b0}),
        .i_pl    ({s_slot, s_degen, s_neg, s_rootc}),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_ovf   (d_ovf),
        .o_pl    (d_pl)
    );

    rmq_pkg::t_slot d_slot;
    logic           d_degen;
    logic [2:0]     d_neg;
    logic [15:0]    d_rootc;
    logic [2:0][15:0] d_val;
    logic [3:0][15:0] n_q;

    assign {d_slot, d_degen, d_neg, d_rootc} = d_pl;

    for (genvar l = 0; l < 3; l++) begin : g_sat
        always_comb begin
            if (d_neg[l]) begin
                if (d_ovf[l] || 32'(d_quo[l]) > 32'(rmq_pkg::Q_MIN_MAG)) begin
                    d_val[l] = 16'h8000;
                end else begin
                    d_val[l] = 16'(-d_quo[l]);
                end
            end else begin
                if (d_ovf[l] || 32'(d_quo[l]) > 32'(rmq_pkg::Q_MAX)) begin
                    d_val[l] = 16'(rmq_pkg::Q_MAX);
                end else begin
                    d_val[l] = 16'(d_quo[l]);
                end
            end
        end
    end

    always_comb begin
        unique case (d_slot)
            rmq_pkg::SLOT_X: n_q = {d_val[2], d_val[1], d_val[0], d_rootc};
            rmq_pkg::SLOT_Y: n_q = {d_val[2], d_val[1], d_rootc, d_val[0]};
            rmq_pkg::SLOT_Z: n_q = {d_val[2], d_rootc, d_val[1], d_val[0]};
            default:         n_q = {d_rootc, d_val[2], d_val[1], d_val[0]};
        endcase
    end

    // output register
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic        r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= d_degen ? 64'd0 : n_q;
            r_out_user <= d_degen;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    `RMQ_ASSERT_SAME(a_degen_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == 64'd0)
    `RMQ_ASSERT_SAME(a_degen_diag, i_clk, i_rst_n, r1_v && r1_degen, r1_slot != rmq_pkg::SLOT_W)
    `RMQ_ASSERT_SAME(a_root_nz, i_clk, i_rst_n, d_v && !d_degen, d_rootc != 16'd0)
    `RMQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !en, r1_v == $past(r1_v))
endmodule
`default_nettype wire
